// ----- design/ttcs_pkg.sv -----
// ----------------------------------------------------------------------------
// ttcs_pkg: shared types and constants
// Register map, payload structs, latency budget and saturation helper for the
// triangle transform / cull / shade pipeline.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  // configuration port
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_COS_Z,
    REG_SIN_Z,
    REG_COS_X,
    REG_SIN_X,
    REG_PROJ_X,
    REG_PROJ_Y,
    REG_PROJ_Z,
    REG_PROJ_ZOFF
  } reg_idx_e;

  typedef struct packed {
    logic signed [17:0] cos_z;
    logic signed [17:0] sin_z;
    logic signed [17:0] cos_x;
    logic signed [17:0] sin_x;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic signed [31:0] proj_zoff;
  } cfg_t;

  localparam cfg_t CfgRst = '{
    cos_z:     18'sd65536,
    sin_z:     18'sd0,
    cos_x:     18'sd65536,
    sin_x:     18'sd0,
    proj_x:    32'sd61680,
    proj_y:    32'sd65536,
    proj_z:    32'sd65543,
    proj_zoff: -32'sd6554
  };

  // one vertex in Q16.16
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // what one vertex lane hands to the merge stage
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] pz;
  } lane_t;

  // result transaction
  typedef struct packed {
    logic               visible;
    logic signed [31:0] sx0;
    logic signed [31:0] sy0;
    logic signed [31:0] sx1;
    logic signed [31:0] sy1;
    logic signed [31:0] sx2;
    logic signed [31:0] sy2;
    logic signed [31:0] depth_sum;
    logic [3:0]         shade;
  } res_t;

  // fixed-point constants
  localparam logic signed [31:0] OneQ16   = 32'sd65536;
  localparam logic signed [31:0] PushZ    = 32'sd524288;
  localparam logic signed [31:0] Int32Max = 32'sh7fffffff;
  localparam logic signed [31:0] Int32Min = 32'sh80000000;
  localparam logic [3:0]         ShadeMax = 4'd12;
  localparam int unsigned        ShadeK   = 13;
  localparam int unsigned        NormBits = 24;

  // latency budget
  localparam int unsigned DivSteps = 31;
  localparam int unsigned DivLat   = DivSteps + 3;
  localparam int unsigned RotLat   = 4;
  localparam int unsigned LaneLat  = RotLat + 2 + DivLat + 2;
  localparam int unsigned FaceLat  = 10;
  localparam int unsigned FaceDly  = LaneLat - RotLat - FaceLat;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = Int32Max;
    end else if (v < -66'sd2147483648) begin
      r = Int32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/ttcs_tri_if.sv -----
// ----------------------------------------------------------------------------
// ttcs_tri_if: triangle input channel
// Valid/ready channel carrying three Q16.16 vertices.
// ----------------------------------------------------------------------------
interface ttcs_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by_coord;
  logic signed [31:0] bz;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    input  ready
  );
  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    output ready
  );
endinterface

// ----- design/ttcs_res_if.sv -----
// ----------------------------------------------------------------------------
// ttcs_res_if: result output channel
// Valid/ready channel carrying screen vertices, depth sum and shade.
// ----------------------------------------------------------------------------
interface ttcs_res_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] sx0;
  logic signed [31:0] sy0;
  logic signed [31:0] sx1;
  logic signed [31:0] sy1;
  logic signed [31:0] sx2;
  logic signed [31:0] sy2;
  logic signed [31:0] depth_sum;
  logic [3:0]         shade;

  modport source (
    output valid, visible, sx0, sy0, sx1, sy1, sx2, sy2, depth_sum, shade,
    input  ready
  );
  modport sink (
    input  valid, visible, sx0, sy0, sx1, sy1, sx2, sy2, depth_sum, shade,
    output ready
  );
endinterface

// ----- design/ttcs_div.sv -----
// ----------------------------------------------------------------------------
// ttcs_div: pipelined signed divider
// 64 / 32 bit signed divide, truncating, clamped to 32 bits. One quotient bit
// per stage; the overflow check up front leaves 31 bits to resolve.
// ----------------------------------------------------------------------------
module ttcs_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o
);
  import ttcs_pkg::*;

  // magnitudes and result sign
  logic [63:0] nmag_q;
  logic [31:0] dmag0_q;
  logic        neg0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q  <= num_i[63] ? 64'(-num_i) : num_i;
      dmag0_q <= den_i[31] ? 32'(-den_i) : den_i;
      neg0_q  <= num_i[63] ^ den_i[31];
    end
  end

  // step pipeline
  logic [31:0]         rem_q  [DivSteps+1];
  logic [DivSteps-1:0] low_q  [DivSteps+1];
  logic [DivSteps-1:0] quo_q  [DivSteps+1];
  logic [31:0]         dmag_q [DivSteps+1];
  logic                neg_q  [DivSteps+1];
  logic                ovf_q  [DivSteps+1];

  logic [32:0] hi_w;
  assign hi_w = nmag_q[63:31];

  // quotient of 2^31 or more saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= hi_w >= {1'b0, dmag0_q};
      rem_q[0]  <= nmag_q[62:31];
      low_q[0]  <= nmag_q[DivSteps-1:0];
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag0_q;
      neg_q[0]  <= neg0_q;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [32:0] t_w;
    logic        ge_w;
    assign t_w  = {rem_q[j], low_q[j][DivSteps-1]};
    assign ge_w = t_w >= {1'b0, dmag_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge_w ? 32'(t_w - {1'b0, dmag_q[j]}) : t_w[31:0];
        low_q[j+1]  <= {low_q[j][DivSteps-2:0], 1'b0};
        quo_q[j+1]  <= {quo_q[j][DivSteps-2:0], ge_w};
        dmag_q[j+1] <= dmag_q[j];
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
      end
    end
  end

  // sign and clamp
  logic signed [31:0] q_w;
  assign q_w = $signed({1'b0, quo_q[DivSteps]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ovf_q[DivSteps]) begin
        quo_o <= neg_q[DivSteps] ? Int32Min : Int32Max;
      end else begin
        quo_o <= neg_q[DivSteps] ? -q_w : q_w;
      end
    end
  end

endmodule

// ----- design/ttcs_vtx_lane.sv -----
// ----------------------------------------------------------------------------
// ttcs_vtx_lane: one vertex lane
// Rotates about Z then X, pushes along Z, projects with three dividers and
// maps to screen pixels. Every register advances only under en_i.
// ----------------------------------------------------------------------------
module ttcs_vtx_lane #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  ttcs_pkg::cfg_t cfg_i,
  input  ttcs_pkg::vec_t vtx_i,
  output ttcs_pkg::vec_t pos_o,
  output ttcs_pkg::lane_t lane_o
);
  import ttcs_pkg::*;

  localparam int unsigned WW  = $clog2(SCREEN_WIDTH + 1) + 1;
  localparam int unsigned WH  = $clog2(SCREEN_HEIGHT + 1) + 1;
  localparam int unsigned PWX = 33 + WW;
  localparam int unsigned PWY = 33 + WH;
  localparam logic signed [WW-1:0] ScrW = WW'(SCREEN_WIDTH);
  localparam logic signed [WH-1:0] ScrH = WH'(SCREEN_HEIGHT);

  // Z rotation products
  logic signed [49:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [31:0] z1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xc_q <= vtx_i.x * cfg_i.cos_z;
      ys_q <= vtx_i.y * cfg_i.sin_z;
      xs_q <= vtx_i.x * cfg_i.sin_z;
      yc_q <= vtx_i.y * cfg_i.cos_z;
      z1_q <= vtx_i.z;
    end
  end

  // Z rotation sums, floored and clamped
  logic signed [50:0] rx_w, ry_w;
  logic signed [31:0] x1_q, y1_q, z2_q;
  assign rx_w = 51'(xc_q) - 51'(ys_q);
  assign ry_w = 51'(xs_q) + 51'(yc_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= sat32(66'($signed(rx_w[50:16])));
      y1_q <= sat32(66'($signed(ry_w[50:16])));
      z2_q <= z1_q;
    end
  end

  // X rotation products
  logic signed [49:0] yc2_q, zs_q, ys2_q, zc_q;
  logic signed [31:0] x2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yc2_q <= y1_q * cfg_i.cos_x;
      zs_q  <= z2_q * cfg_i.sin_x;
      ys2_q <= y1_q * cfg_i.sin_x;
      zc_q  <= z2_q * cfg_i.cos_x;
      x2_q  <= x1_q;
    end
  end

  // X rotation sums and push along Z
  logic signed [50:0] ry2_w, rz2_w;
  logic signed [31:0] zr_w;
  vec_t               pos_q;
  assign ry2_w = 51'(yc2_q) - 51'(zs_q);
  assign rz2_w = 51'(ys2_q) + 51'(zc_q);
  assign zr_w  = sat32(66'($signed(rz2_w[50:16])));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q.x <= x2_q;
      pos_q.y <= sat32(66'($signed(ry2_w[50:16])));
      pos_q.z <= sat32(66'(zr_w) + 66'(PushZ));
    end
  end
  assign pos_o = pos_q;

  // projection products
  logic signed [63:0] pxp_q, pyp_q, pzp_q;
  logic signed [31:0] pd_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxp_q <= pos_q.x * cfg_i.proj_x;
      pyp_q <= pos_q.y * cfg_i.proj_y;
      pzp_q <= pos_q.z * cfg_i.proj_z;
      pd_q  <= pos_q.z;
    end
  end

  // numerators; zero depth divides by one
  logic signed [63:0] nx_q, ny_q, nz_q;
  logic signed [63:0] zoff_w;
  logic signed [31:0] den_q;
  assign zoff_w = 64'(cfg_i.proj_zoff) <<< 16;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q  <= pxp_q;
      ny_q  <= pyp_q;
      nz_q  <= pzp_q + zoff_w;
      den_q <= (pd_q == '0) ? OneQ16 : pd_q;
    end
  end

  logic signed [31:0] qx_w, qy_w, qz_w;
  ttcs_div u_div_x (.clk_i, .en_i, .num_i(nx_q), .den_i(den_q), .quo_o(qx_w));
  ttcs_div u_div_y (.clk_i, .en_i, .num_i(ny_q), .den_i(den_q), .quo_o(qy_w));
  ttcs_div u_div_z (.clk_i, .en_i, .num_i(nz_q), .den_i(den_q), .quo_o(qz_w));

  // screen scale
  logic signed [32:0]    qx1_w, qy1_w;
  logic signed [PWX-1:0] sxp_q;
  logic signed [PWY-1:0] syp_q;
  logic signed [31:0]    pzd_q;
  assign qx1_w = 33'(qx_w) + 33'(OneQ16);
  assign qy1_w = 33'(qy_w) + 33'(OneQ16);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxp_q <= qx1_w * ScrW;
      syp_q <= qy1_w * ScrH;
      pzd_q <= qz_w;
    end
  end

  // halve toward zero and clamp
  logic signed [PWX-1:0] sxr_w;
  logic signed [PWY-1:0] syr_w;
  lane_t                 lane_q;
  assign sxr_w = sxp_q + PWX'(sxp_q[PWX-1]);
  assign syr_w = syp_q + PWY'(syp_q[PWY-1]);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q.sx <= sat32(66'($signed(sxr_w[PWX-1:1])));
      lane_q.sy <= sat32(66'($signed(syr_w[PWY-1:1])));
      lane_q.pz <= pzd_q;
    end
  end
  assign lane_o = lane_q;

endmodule

// ----- design/ttcs_face.sv -----
// ----------------------------------------------------------------------------
// ttcs_face: face normal, cull and shade
// Cross product of the edges, normalize to 24 bits, dot with the first
// vertex, integer shade from normal z. Output delayed to line up with lanes.
// ----------------------------------------------------------------------------
module ttcs_face (
  input  logic           clk_i,
  input  logic           en_i,
  input  ttcs_pkg::vec_t p0_i,
  input  ttcs_pkg::vec_t p1_i,
  input  ttcs_pkg::vec_t p2_i,
  output logic           visible_o,
  output logic [3:0]     shade_o
);
  import ttcs_pkg::*;

  // edges, clamped
  vec_t e1_q, e2_q;
  vec_t p0d_q [7];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q.x   <= sat32(66'(p1_i.x) - 66'(p0_i.x));
      e1_q.y   <= sat32(66'(p1_i.y) - 66'(p0_i.y));
      e1_q.z   <= sat32(66'(p1_i.z) - 66'(p0_i.z));
      e2_q.x   <= sat32(66'(p2_i.x) - 66'(p0_i.x));
      e2_q.y   <= sat32(66'(p2_i.y) - 66'(p0_i.y));
      e2_q.z   <= sat32(66'(p2_i.z) - 66'(p0_i.z));
      p0d_q[0] <= p0_i;
      for (int i = 1; i < 7; i++) p0d_q[i] <= p0d_q[i-1];
    end
  end

  // cross product terms
  logic signed [63:0] pr_q [6];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= e1_q.y * e2_q.z;
      pr_q[1] <= e1_q.z * e2_q.y;
      pr_q[2] <= e1_q.z * e2_q.x;
      pr_q[3] <= e1_q.x * e2_q.z;
      pr_q[4] <= e1_q.x * e2_q.y;
      pr_q[5] <= e1_q.y * e2_q.x;
    end
  end

  logic signed [63:0] n_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) n_q[i] <= pr_q[2*i] - pr_q[2*i+1];
    end
  end

  // magnitudes and their OR
  logic [63:0] mag_q [3][3];
  logic        sgn_q [3][3];
  logic [63:0] orv_q;
  logic [63:0] mag_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) mag_w[i] = n_q[i][63] ? 64'(-n_q[i]) : n_q[i];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      orv_q <= mag_w[0] | mag_w[1] | mag_w[2];
      for (int i = 0; i < 3; i++) begin
        mag_q[0][i] <= mag_w[i];
        sgn_q[0][i] <= n_q[i][63];
        mag_q[1][i] <= mag_q[0][i];
        sgn_q[1][i] <= sgn_q[0][i];
        mag_q[2][i] <= mag_q[1][i];
        sgn_q[2][i] <= sgn_q[1][i];
      end
    end
  end

  // top nonzero byte
  logic [2:0] grp_w, grp_q;
  logic [7:0] byte_q;
  always_comb begin
    grp_w = '0;
    for (int g = 0; g < 8; g++) begin
      if (orv_q[g*8 +: 8] != '0) grp_w = 3'(g);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q  <= grp_w;
      byte_q <= orv_q[{grp_w, 3'b000} +: 8];
    end
  end

  // leading one within the byte gives the shift
  logic [2:0] bit_w;
  logic [5:0] pos_w, s_q;
  always_comb begin
    bit_w = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_q[b]) bit_w = 3'(b);
    end
  end
  assign pos_w = {grp_q, bit_w};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= (pos_w > 6'(NormBits - 1)) ? pos_w - 6'(NormBits - 1) : '0;
    end
  end

  // reduced normal
  logic signed [24:0] r_q [3];
  logic signed [24:0] r_w [3];
  logic [63:0]        sh_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_w[i] = mag_q[2][i] >> s_q;
      r_w[i]  = sgn_q[2][i] ? -$signed({1'b0, sh_w[i][23:0]})
                            :  $signed({1'b0, sh_w[i][23:0]});
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) r_q[i] <= r_w[i];
    end
  end

  // dot terms and squares
  logic signed [56:0] dt_q [3];
  logic signed [49:0] sq_q [3];
  logic               r2neg_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dt_q[0] <= r_q[0] * p0d_q[6].x;
      dt_q[1] <= r_q[1] * p0d_q[6].y;
      dt_q[2] <= r_q[2] * p0d_q[6].z;
      for (int i = 0; i < 3; i++) sq_q[i] <= r_q[i] * r_q[i];
      r2neg_q <= r_q[2][24];
    end
  end

  // dot sign, squared length, shade bound
  logic signed [58:0] dot_w;
  logic [59:0]        l2_q, rhs_q;
  logic               dneg_q, r2neg2_q;
  assign dot_w = 59'(dt_q[0]) + 59'(dt_q[1]) + 59'(dt_q[2]);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q   <= dot_w[58];
      l2_q     <= 60'(sq_q[0]) + 60'(sq_q[1]) + 60'(sq_q[2]);
      rhs_q    <= 60'(sq_q[2]) * 60'(ShadeK * ShadeK);
      r2neg2_q <= r2neg_q;
    end
  end

  // largest k with k*k*L2 <= 169*m*m
  logic [3:0] best_w, shade_w;
  always_comb begin
    best_w = '0;
    for (int k = 1; k <= ShadeK; k++) begin
      if (l2_q * 60'(k * k) <= rhs_q) best_w = 4'(k);
    end
    shade_w = (r2neg2_q && best_w != '0 && best_w <= ShadeMax) ? best_w : '0;
  end

  logic       vis_q;
  logic [3:0] shd_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis_q <= dneg_q;
      shd_q <= shade_w;
    end
  end

  // align with the vertex lanes
  logic [4:0] dly_q [FaceDly];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= {vis_q, shd_q};
      for (int i = 1; i < FaceDly; i++) dly_q[i] <= dly_q[i-1];
    end
  end
  assign visible_o = dly_q[FaceDly-1][4];
  assign shade_o   = dly_q[FaceDly-1][3:0];

endmodule

// ----- design/ttcs_merge.sv -----
// ----------------------------------------------------------------------------
// ttcs_merge: lane merge and output register
// Sums lane depths, zeroes culled triangles and holds the result transaction
// until the sink takes it.
// ----------------------------------------------------------------------------
module ttcs_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  ttcs_pkg::lane_t lane_i [3],
  input  logic            visible_i,
  input  logic [3:0]      shade_i,
  input  logic            out_ready_i,
  output logic            take_o,
  output logic            out_valid_o,
  output ttcs_pkg::res_t  res_o
);
  import ttcs_pkg::*;

  logic signed [33:0] ds_w;
  res_t               res_d, res_q;
  logic               out_valid_q;

  // combine lanes
  assign ds_w = 34'(lane_i[0].pz) + 34'(lane_i[1].pz) + 34'(lane_i[2].pz);

  always_comb begin
    res_d = '0;
    if (visible_i) begin
      res_d.visible   = 1'b1;
      res_d.sx0       = lane_i[0].sx;
      res_d.sy0       = lane_i[0].sy;
      res_d.sx1       = lane_i[1].sx;
      res_d.sy1       = lane_i[1].sy;
      res_d.sx2       = lane_i[2].sx;
      res_d.sy2       = lane_i[2].sy;
      res_d.depth_sum = sat32(66'(ds_w));
      res_d.shade     = shade_i;
    end
  end

  // output slot
  assign take_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && vld_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/triangle_transform_cull_shade_top.sv -----
// ----------------------------------------------------------------------------
// triangle_transform_cull_shade_top: triangle transform, cull and shade
//
//   channel | dir | transaction
//   --------+-----+--------------------------------------------------
//   tri_i   | in  | three Q16.16 vertices (ax..cz)
//   res_o   | out | visible, screen vertices, depth_sum, shade
//   apb     | in  | eight rotation / projection registers
//
// One triangle per cycle unless a stalled output freezes the pipeline. 42
// stages set by the 31-step dividers of each vertex lane, plus the output reg.
// Reset clears the valid pipeline and loads register defaults; no sweep.
// A stalled output freezes the pipeline only when its last stage is full,
// so bubbles close up while a result waits.
// ----------------------------------------------------------------------------
module triangle_transform_cull_shade_top #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ttcs_tri_if.sink                      tri_i,
  ttcs_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttcs_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ttcs_pkg::*;

  // configuration registers
  cfg_t     cfg_q;
  reg_idx_e ridx_w;
  logic     wr_w;
  assign ridx_w = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign pready = 1'b1;
  assign wr_w   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else if (wr_w) begin
      unique case (ridx_w)
        REG_COS_Z:     cfg_q.cos_z     <= pwdata[17:0];
        REG_SIN_Z:     cfg_q.sin_z     <= pwdata[17:0];
        REG_COS_X:     cfg_q.cos_x     <= pwdata[17:0];
        REG_SIN_X:     cfg_q.sin_x     <= pwdata[17:0];
        REG_PROJ_X:    cfg_q.proj_x    <= pwdata;
        REG_PROJ_Y:    cfg_q.proj_y    <= pwdata;
        REG_PROJ_Z:    cfg_q.proj_z    <= pwdata;
        REG_PROJ_ZOFF: cfg_q.proj_zoff <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (ridx_w)
      REG_COS_Z:     prdata = 32'(cfg_q.cos_z);
      REG_SIN_Z:     prdata = 32'(cfg_q.sin_z);
      REG_COS_X:     prdata = 32'(cfg_q.cos_x);
      REG_SIN_X:     prdata = 32'(cfg_q.sin_x);
      REG_PROJ_X:    prdata = cfg_q.proj_x;
      REG_PROJ_Y:    prdata = cfg_q.proj_y;
      REG_PROJ_Z:    prdata = cfg_q.proj_z;
      REG_PROJ_ZOFF: prdata = cfg_q.proj_zoff;
      default:       prdata = '0;
    endcase
  end

  // pipeline advance and valid tracking
  logic               en_w, take_w;
  logic [LaneLat-1:0] vld_q;
  assign en_w        = !vld_q[LaneLat-1] || take_w;
  assign tri_i.ready = en_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_w) begin
      vld_q <= {vld_q[LaneLat-2:0], tri_i.valid};
    end
  end

  // vertex lanes
  vec_t  vtx_w  [3];
  vec_t  pos_w  [3];
  lane_t lane_w [3];
  assign vtx_w[0] = '{x: tri_i.ax, y: tri_i.ay,       z: tri_i.az};
  assign vtx_w[1] = '{x: tri_i.bx, y: tri_i.by_coord, z: tri_i.bz};
  assign vtx_w[2] = '{x: tri_i.cx, y: tri_i.cy,       z: tri_i.cz};

  for (genvar l = 0; l < 3; l++) begin : g_lane
    ttcs_vtx_lane #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_lane (
      .clk_i,
      .en_i  (en_w),
      .cfg_i (cfg_q),
      .vtx_i (vtx_w[l]),
      .pos_o (pos_w[l]),
      .lane_o(lane_w[l])
    );
  end

  // face normal path
  logic       vis_w;
  logic [3:0] shade_w;
  ttcs_face u_face (
    .clk_i,
    .en_i     (en_w),
    .p0_i     (pos_w[0]),
    .p1_i     (pos_w[1]),
    .p2_i     (pos_w[2]),
    .visible_o(vis_w),
    .shade_o  (shade_w)
  );

  // merge and output
  res_t res_w;
  logic ovld_w;
  ttcs_merge u_merge (
    .clk_i,
    .rst_ni,
    .vld_i      (vld_q[LaneLat-1]),
    .lane_i     (lane_w),
    .visible_i  (vis_w),
    .shade_i    (shade_w),
    .out_ready_i(res_o.ready),
    .take_o     (take_w),
    .out_valid_o(ovld_w),
    .res_o      (res_w)
  );

  assign res_o.valid     = ovld_w;
  assign res_o.visible   = res_w.visible;
  assign res_o.sx0       = res_w.sx0;
  assign res_o.sy0       = res_w.sy0;
  assign res_o.sx1       = res_w.sx1;
  assign res_o.sy1       = res_w.sy1;
  assign res_o.sx2       = res_w.sx2;
  assign res_o.sy2       = res_w.sy2;
  assign res_o.depth_sum = res_w.depth_sum;
  assign res_o.shade     = res_w.shade;

`ifndef NO_ASSERTIONS
  // an accepted triangle enters the valid pipeline
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_i.valid && tri_i.ready) |=> vld_q[0])
    else $error("accepted triangle not tracked");

  // culled triangles carry all-zero fields; checked on shade, depth_sum, sx0, sy2
  a_cull_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.visible) |->
      (res_o.shade == '0 && res_o.depth_sum == '0 && res_o.sx0 == '0 &&
       res_o.sy2 == '0))
    else $error("culled result has nonzero fields");

  // shade stays in range
  a_shade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.shade <= ShadeMax))
    else $error("shade out of range");

  // a full last stage never moves while the output is blocked
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LaneLat-1] && res_o.valid && !res_o.ready) |-> !tri_i.ready)
    else $error("pipeline advanced into a blocked output");
`endif

endmodule
